/* rtl/core/fobf_pkg.sv */
// Package for the first-fit / best-fit partition allocator.
// Holds the item types, status and kind codes, the scan link type and the FSM states.
// No dependencies; every other file in rtl/core uses it.
`default_nettype none

package fobf_pkg;

    // Default sizes of the partition table.
    localparam int NUM_PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF      = 16;

    // Fixed field widths of the item payloads.
    localparam int AMOUNT_W   = 16;
    localparam int PART_NUM_W = 5;
    localparam int FREE_W     = 20;
    localparam int STATUS_W   = 3;

    // Item kinds.
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // Placement policies.
    localparam logic POLICY_FIRST = 1'b0;
    localparam logic POLICY_BEST  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_LOADED    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_SKIPPED   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

    // Input item.
    typedef struct packed {
        logic                kind;
        logic [AMOUNT_W-1:0] amount;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [PART_NUM_W-1:0] partition_number;
        logic [FREE_W-1:0]     free_total;
    } out_item_t;

    // Control part of the search record handed from cell to cell.
    typedef struct packed {
        logic active;
        logic found;
    } scan_link_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/fobf_cell.sv */
// One cell of the partition chain: stores one partition's free size and
// compares it against the passing search record. Depends on fobf_pkg.
`default_nettype none

module fobf_cell #(
    parameter int SIZE_BITS  = fobf_pkg::SIZE_BITS_DEF,
    parameter int CNT_W      = 5,
    parameter int IDX_W      = 4,
    parameter int CELL_INDEX = 0
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            policy,
    input  wire [fobf_pkg::AMOUNT_W-1:0]   req_amount,
    input  wire [CNT_W-1:0]                loaded_count,
    input  wire                            wr_en,
    input  wire [IDX_W-1:0]                wr_idx,
    input  wire [SIZE_BITS-1:0]            wr_data,
    input  wire fobf_pkg::scan_link_t      link_in,
    input  wire [SIZE_BITS-1:0]            best_val_in,
    input  wire [IDX_W-1:0]                best_idx_in,
    output fobf_pkg::scan_link_t           link_out,
    output logic [SIZE_BITS-1:0]           best_val_out,
    output logic [IDX_W-1:0]               best_idx_out
);

    localparam int CW = (SIZE_BITS > fobf_pkg::AMOUNT_W) ? SIZE_BITS : fobf_pkg::AMOUNT_W;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);

    logic [SIZE_BITS-1:0]  size_reg;
    fobf_pkg::scan_link_t  link_reg;
    fobf_pkg::scan_link_t  link_next;
    logic [SIZE_BITS-1:0]  best_val_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic                  loaded;
    logic                  fits;
    logic                  take;

    // Stored free size; written by loads and by allocation updates.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == MY_IDX))
        begin
            size_reg <= wr_data;
        end
    end

    // Decide whether this cell becomes the current pick.
    always_comb
    begin
        loaded = (MY_CNT < loaded_count);
        fits   = loaded && (CW'(size_reg) >= CW'(req_amount));
        take   = link_in.active && fits &&
                 (!link_in.found || ((policy == fobf_pkg::POLICY_BEST) &&
                                     (size_reg < best_val_in)));
        link_next.active = link_in.active;
        link_next.found  = link_in.found || take;
    end

    // Search record control toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    // Best candidate so far travels along with the record.
    always_ff @(posedge clk)
    begin
        best_val_reg <= take ? size_reg : best_val_in;
        best_idx_reg <= take ? MY_IDX : best_idx_in;
    end

    assign link_out     = link_reg;
    assign best_val_out = best_val_reg;
    assign best_idx_out = best_idx_reg;

endmodule

`default_nettype wire

/* rtl/core/first_or_best_fit_allocator_top.sv */
// Top level of the first-fit / best-fit partition allocator.
// Depends on fobf_pkg and fobf_cell.
`default_nettype none

// Usage:
// The input channel (in_valid, in_stall, in_item) carries load and request items;
// the output channel (out_valid, out_stall, out_item) returns one result item per input item.
// cfg_we with cfg_data selects the placement rule (0 first fit, 1 best fit); write it
// only while the block is idle.
// A load or a skipped request goes from acceptance to the resolve state, which writes its result.
// A request that searches the table enters the first of NUM_PARTITIONS cells in
// the cycle after acceptance and moves one cell per cycle; the pick is latched as the
// record leaves the last cell, and the chosen entry and the result are written in the
// resolve state. The next item is accepted in the cycle after the result is
// registered, so the block works on one item at a time.
// A finished result waits in the output register; the next item is accepted
// while it waits, and only the write of the following result waits on out_stall.
// Reset empties the table, clears the failure flag, the free total and the
// policy (first fit). The stored partition sizes are not cleared.

module first_or_best_fit_allocator_top #(
    parameter int NUM_PARTITIONS = fobf_pkg::NUM_PARTITIONS_DEF,
    parameter int SIZE_BITS      = fobf_pkg::SIZE_BITS_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_stall,
    input  wire fobf_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire                      out_stall,
    output fobf_pkg::out_item_t      out_item,
    input  wire                      cfg_we,
    input  wire                      cfg_data
);

    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);
    localparam int CW    = (SIZE_BITS > fobf_pkg::AMOUNT_W) ? SIZE_BITS : fobf_pkg::AMOUNT_W;
    localparam logic [CNT_W-1:0]     FULL_COUNT = CNT_W'(NUM_PARTITIONS);
    localparam logic [SIZE_BITS-1:0] SIZE_MAX   = {SIZE_BITS{1'b1}};

    fobf_pkg::state_t                state_reg;
    fobf_pkg::state_t                state_next;
    logic                            kind_reg;
    logic [fobf_pkg::AMOUNT_W-1:0]   amount_reg;
    logic                            policy_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic                            halted_reg;
    logic                            halted_next;
    logic [fobf_pkg::FREE_W-1:0]     free_sum_reg;
    logic [fobf_pkg::FREE_W-1:0]     free_sum_next;
    logic                            found_reg;
    logic [IDX_W-1:0]                pick_idx_reg;
    logic [SIZE_BITS-1:0]            pick_val_reg;
    logic                            scan_start_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    fobf_pkg::out_item_t             out_item_reg;
    fobf_pkg::out_item_t             out_item_next;

    logic                            accept;
    logic                            start_scan;
    logic                            commit;
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_idx;
    logic [SIZE_BITS-1:0]            wr_data;
    logic [CW-1:0]                   amt_w;
    logic [SIZE_BITS-1:0]            sat_amount;
    logic [CW-1:0]                   shrunk_w;

    fobf_pkg::scan_link_t            link [0:NUM_PARTITIONS];
    logic [SIZE_BITS-1:0]            bval [0:NUM_PARTITIONS];
    logic [IDX_W-1:0]                bidx [0:NUM_PARTITIONS];

    // Head of the chain: a fresh search record enters once the request amount is latched.
    assign link[0].active = scan_start_reg;
    assign link[0].found  = 1'b0;
    assign bval[0]        = '0;
    assign bidx[0]        = '0;

    // The row of cells, one per partition.
    for (genvar g = 0; g < NUM_PARTITIONS; g++)
    begin : g_cell
        fobf_cell #(
            .SIZE_BITS  (SIZE_BITS),
            .CNT_W      (CNT_W),
            .IDX_W      (IDX_W),
            .CELL_INDEX (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .policy       (policy_reg),
            .req_amount   (amount_reg),
            .loaded_count (count_reg),
            .wr_en        (wr_en),
            .wr_idx       (wr_idx),
            .wr_data      (wr_data),
            .link_in      (link[g]),
            .best_val_in  (bval[g]),
            .best_idx_in  (bidx[g]),
            .link_out     (link[g+1]),
            .best_val_out (bval[g+1]),
            .best_idx_out (bidx[g+1])
        );
    end

    // Arithmetic on the latched amount.
    always_comb
    begin
        amt_w      = CW'(amount_reg);
        sat_amount = (amt_w > CW'(SIZE_MAX)) ? SIZE_MAX : amt_w[SIZE_BITS-1:0];
        shrunk_w   = CW'(pick_val_reg) - amt_w;
    end

    // Controller: next state, handshake and the result of each item.
    always_comb
    begin
        state_next     = state_reg;
        in_stall       = 1'b1;
        accept         = 1'b0;
        start_scan     = 1'b0;
        commit         = 1'b0;
        wr_en          = 1'b0;
        wr_idx         = pick_idx_reg;
        wr_data        = shrunk_w[SIZE_BITS-1:0];
        count_next     = count_reg;
        halted_next    = halted_reg;
        free_sum_next  = free_sum_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            fobf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
                if (in_valid)
                begin
                    start_scan = (in_item.kind == fobf_pkg::KIND_REQUEST) && !halted_reg;
                    state_next = start_scan ? fobf_pkg::ST_SCAN : fobf_pkg::ST_RESOLVE;
                end
            end
            fobf_pkg::ST_SCAN:
            begin
                if (link[NUM_PARTITIONS].active)
                begin
                    state_next = fobf_pkg::ST_RESOLVE;
                end
            end
            fobf_pkg::ST_RESOLVE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    commit         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = fobf_pkg::ST_IDLE;
                    out_item_next.partition_number = '0;
                    if (kind_reg == fobf_pkg::KIND_LOAD)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            out_item_next.status = fobf_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_idx        = count_reg[IDX_W-1:0];
                            wr_data       = sat_amount;
                            count_next    = count_reg + CNT_W'(1);
                            free_sum_next = free_sum_reg + fobf_pkg::FREE_W'(sat_amount);
                            out_item_next.status = fobf_pkg::STATUS_LOADED;
                        end
                    end
                    else if (halted_reg)
                    begin
                        out_item_next.status = fobf_pkg::STATUS_SKIPPED;
                    end
                    else if (!found_reg)
                    begin
                        halted_next          = 1'b1;
                        out_item_next.status = fobf_pkg::STATUS_NO_FIT;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        free_sum_next = free_sum_reg - fobf_pkg::FREE_W'(amount_reg);
                        out_item_next.status = fobf_pkg::STATUS_ALLOCATED;
                        out_item_next.partition_number =
                            fobf_pkg::PART_NUM_W'({1'b0, pick_idx_reg} + (IDX_W + 1)'(1));
                    end
                    out_item_next.free_total = free_sum_next;
                end
            end
            default:
            begin
                state_next = fobf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fobf_pkg::ST_IDLE;
            policy_reg     <= fobf_pkg::POLICY_FIRST;
            count_reg      <= '0;
            halted_reg     <= 1'b0;
            free_sum_reg   <= '0;
            scan_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            halted_reg     <= halted_next;
            free_sum_reg   <= free_sum_next;
            scan_start_reg <= start_scan;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                policy_reg <= cfg_data;
            end
        end
    end

    // Payload registers: the accepted item, the search outcome and the result item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= in_item.kind;
            amount_reg <= in_item.amount;
        end
        if (link[NUM_PARTITIONS].active)
        begin
            found_reg    <= link[NUM_PARTITIONS].found;
            pick_idx_reg <= bidx[NUM_PARTITIONS];
            pick_val_reg <= bval[NUM_PARTITIONS];
        end
        if (commit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    logic [NUM_PARTITIONS-1:0] scan_active;

    for (genvar a = 0; a < NUM_PARTITIONS; a++)
    begin : g_scan_active
        assign scan_active[a] = link[a+1].active;
    end

    // Only one search record may be in flight along the chain.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(scan_active))
        else $error("more than one search record in the cell chain");

    // The record leaves the chain only while the controller waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        link[NUM_PARTITIONS].active |-> (state_reg == fobf_pkg::ST_SCAN))
        else $error("search record left the chain outside a scan");

    // A granted partition is always one that has been loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (kind_reg == fobf_pkg::KIND_REQUEST) && !halted_reg && found_reg)
        |-> (CNT_W'(pick_idx_reg) < count_reg))
        else $error("allocation picked a partition that was never loaded");

    // The failure flag only clears through reset.
    assert property (@(posedge clk) disable iff (!rst_n) !$fell(halted_reg))
        else $error("failure flag cleared without reset");
`endif

endmodule

`default_nettype wire
